/* design/ecc_pkg.sv */
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants of the elastic circle collision core.
// ----------------------------------------------------------------------------
package ecc_pkg;

	localparam int QB    = 27;
	localparam int NW    = 90;
	localparam int DENW  = 64;
	localparam int LANES = 4;

	localparam int LANE_FX = 0;
	localparam int LANE_FY = 1;
	localparam int LANE_SX = 2;
	localparam int LANE_SY = 3;

	typedef struct packed {
		logic               func;
		logic signed [23:0] rel_x;
		logic signed [23:0] rel_y;
		logic signed [23:0] first_vel_x;
		logic signed [23:0] first_vel_y;
		logic [15:0]        first_mass;
		logic [22:0]        first_size;
		logic signed [23:0] second_vel_x;
		logic signed [23:0] second_vel_y;
		logic [15:0]        second_mass;
		logic [22:0]        second_size_x;
		logic [22:0]        second_size_y;
	} ecc_pair_t;

	typedef struct packed {
		logic               hit;
		logic signed [23:0] new_first_vel_x;
		logic signed [23:0] new_first_vel_y;
		logic signed [23:0] new_second_vel_x;
		logic signed [23:0] new_second_vel_y;
	} ecc_result_t;

	typedef struct packed {
		logic               hit;
		logic               den_zero;
		logic               neg_x;
		logic               neg_y;
		logic signed [23:0] v1x;
		logic signed [23:0] v1y;
		logic signed [23:0] v2x;
		logic signed [23:0] v2y;
	} ecc_side_t;

	typedef struct packed {
		ecc_side_t                   side;
		logic [DENW-1:0]             den;
		logic [LANES-1:0][DENW-1:0]  rem;
		logic [LANES-1:0][QB-1:0]    nq;
	} ecc_div_t;

	function automatic logic signed [23:0] ecc_apply(
		input logic signed [23:0] v,
		input logic [QB-1:0]      q,
		input logic               sub
	);
		logic [QB+1:0]      s;
		logic signed [23:0] r;
		s = {{(QB+2-24){v[23]}}, v};
		if (sub) begin
			s = s - {2'b00, q};
		end else begin
			s = s + {2'b00, q};
		end
		if (!s[QB+1] && (|s[QB:23])) begin
			r = 24'sh7FFFFF;
		end else if (s[QB+1] && !(&s[QB:23])) begin
			r = 24'sh800000;
		end else begin
			r = s[23:0];
		end
		return r;
	endfunction

endpackage

/* design/ecc_stream_if.sv */
// ----------------------------------------------------------------------------
// ecc_stream_if
// Valid/ready stream carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ecc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/ecc_geom.sv */
// ----------------------------------------------------------------------------
// ecc_geom
// Six-stage front end: overlap and approach test, impulse numerators and
// the shared denominator, handed to the divider chain.
// ----------------------------------------------------------------------------
module ecc_geom import ecc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_i,
	input  ecc_pair_t p_i,
	output logic      vld_o,
	output ecc_div_t  d_o
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	ecc_pair_t          p_s1;
	logic signed [24:0] dvx_s1, dvy_s1;
	logic [23:0]        ssum_s1;

	logic [23:0]               arx, ary;
	logic [47:0]               rxx_s2, ryy_s2, sqc_s2;
	logic signed [48:0]        px_s2, py_s2;
	logic [45:0]               sqx_s2, sqy_s2;
	logic [LANES-1:0][39:0]    pm_s2;
	logic [16:0]               msum_s2;
	logic                      func_s2;
	ecc_side_t                 side_s2;

	logic [47:0]               d2_s3, thr_s3;
	logic signed [49:0]        dot_s3;
	logic [LANES-1:0][39:0]    pm_s3;
	logic [16:0]               msum_s3;
	logic                      func_s3;
	ecc_side_t                 side_s3;
	ecc_side_t                 side_nx;

	logic [51:0]               d2k;
	logic [48:0]               absd_s4;
	logic [40:0]               dlo_s4, dhi_s4;
	logic [LANES-1:0][39:0]    pm_s4;
	ecc_side_t                 side_s4;

	logic [DENW-1:0]           den_s5;
	logic [LANES-1:0][44:0]    pp00_s5, pp01_s5;
	logic [LANES-1:0][43:0]    pp10_s5, pp11_s5;
	ecc_side_t                 side_s5;

	logic [LANES-1:0][NW-1:0]  num;
	ecc_div_t                  d_s6;

	assign arx = p_s1.rel_x[23] ? (24'd0 - p_s1.rel_x) : p_s1.rel_x;
	assign ary = p_s1.rel_y[23] ? (24'd0 - p_s1.rel_y) : p_s1.rel_y;

	assign d2k = func_s3 ? (({4'b0, d2_s3} << 3) + {4'b0, d2_s3}) : ({4'b0, d2_s3} << 2);

	always_comb begin
		side_nx          = side_s3;
		side_nx.hit      = (d2k < {4'b0, thr_s3}) && dot_s3[49];
		side_nx.den_zero = (msum_s3 == 17'd0);
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num[l] = (NW'(pp00_s5[l]) + (NW'(pp01_s5[l]) << 20)
				+ (NW'(pp10_s5[l]) << 25) + (NW'(pp11_s5[l]) << 45)) << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p_i;
			dvx_s1  <= {p_i.second_vel_x[23], p_i.second_vel_x}
				- {p_i.first_vel_x[23], p_i.first_vel_x};
			dvy_s1  <= {p_i.second_vel_y[23], p_i.second_vel_y}
				- {p_i.first_vel_y[23], p_i.first_vel_y};
			ssum_s1 <= {1'b0, p_i.first_size} + {1'b0, p_i.second_size_x};

			rxx_s2  <= p_s1.rel_x * p_s1.rel_x;
			ryy_s2  <= p_s1.rel_y * p_s1.rel_y;
			px_s2   <= dvx_s1 * p_s1.rel_x;
			py_s2   <= dvy_s1 * p_s1.rel_y;
			sqc_s2  <= ssum_s1 * ssum_s1;
			sqx_s2  <= p_s1.second_size_x * p_s1.second_size_x;
			sqy_s2  <= p_s1.second_size_y * p_s1.second_size_y;
			pm_s2[LANE_FX] <= arx * p_s1.second_mass;
			pm_s2[LANE_FY] <= ary * p_s1.second_mass;
			pm_s2[LANE_SX] <= arx * p_s1.first_mass;
			pm_s2[LANE_SY] <= ary * p_s1.first_mass;
			msum_s2 <= {1'b0, p_s1.first_mass} + {1'b0, p_s1.second_mass};
			func_s2 <= p_s1.func;
			side_s2.hit      <= 1'b0;
			side_s2.den_zero <= 1'b0;
			side_s2.neg_x    <= p_s1.rel_x[23];
			side_s2.neg_y    <= p_s1.rel_y[23];
			side_s2.v1x      <= p_s1.first_vel_x;
			side_s2.v1y      <= p_s1.first_vel_y;
			side_s2.v2x      <= p_s1.second_vel_x;
			side_s2.v2y      <= p_s1.second_vel_y;

			d2_s3   <= rxx_s2 + ryy_s2;
			dot_s3  <= px_s2 + py_s2;
			thr_s3  <= func_s2 ? (48'(sqx_s2) + 48'(sqy_s2)) : sqc_s2;
			pm_s3   <= pm_s2;
			msum_s3 <= msum_s2;
			func_s3 <= func_s2;
			side_s3 <= side_s2;

			absd_s4 <= dot_s3[49] ? 49'(50'd0 - dot_s3) : dot_s3[48:0];
			dlo_s4  <= msum_s3 * d2_s3[23:0];
			dhi_s4  <= msum_s3 * d2_s3[47:24];
			pm_s4   <= pm_s3;
			side_s4 <= side_nx;

			den_s5  <= 64'({24'd0, dlo_s4}) + 64'({dhi_s4, 24'd0});
			for (int l = 0; l < LANES; l++) begin
				pp00_s5[l] <= absd_s4[24:0]  * pm_s4[l][19:0];
				pp01_s5[l] <= absd_s4[24:0]  * pm_s4[l][39:20];
				pp10_s5[l] <= absd_s4[48:25] * pm_s4[l][19:0];
				pp11_s5[l] <= absd_s4[48:25] * pm_s4[l][39:20];
			end
			side_s5 <= side_s4;

			for (int l = 0; l < LANES; l++) begin
				d_s6.rem[l] <= DENW'(num[l][NW-1:QB]);
				d_s6.nq[l]  <= num[l][QB-1:0];
			end
			d_s6.den  <= den_s5;
			d_s6.side <= side_s5;
		end
	end

	assign vld_o = vld_s6;
	assign d_o   = d_s6;

endmodule

/* design/ecc_div_step.sv */
// ----------------------------------------------------------------------------
// ecc_div_step
// One registered restoring-division step: one quotient bit on each lane.
// ----------------------------------------------------------------------------
module ecc_div_step import ecc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     vld_i,
	input  ecc_div_t d_i,
	output logic     vld_o,
	output ecc_div_t d_o
);

	logic [LANES-1:0][DENW:0] trial;
	ecc_div_t                 nxt;
	logic                     vld_q;
	ecc_div_t                 d_q;

	always_comb begin
		nxt = d_i;
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {d_i.rem[l], d_i.nq[l][QB-1]};
			if (trial[l] >= {1'b0, d_i.den}) begin
				nxt.rem[l] = DENW'(trial[l] - {1'b0, d_i.den});
				nxt.nq[l]  = {d_i.nq[l][QB-2:0], 1'b1};
			end else begin
				nxt.rem[l] = trial[l][DENW-1:0];
				nxt.nq[l]  = {d_i.nq[l][QB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

/* design/elastic_circle_collision_core.sv */
// ----------------------------------------------------------------------------
// elastic_circle_collision_core
// Two-body elastic collision of one body pair per beat.
// ----------------------------------------------------------------------------
// Usage:
//   pair   : sink stream, one body pair per beat (ecc_pair_t).
//   result : source stream, one result per pair, in order (ecc_result_t).
//   A pair accepted at one clock edge passes six front-end stages, 27
//   divider steps (one quotient bit per step on four lanes) and the output
//   register before its result is valid.
//   Throughput is one pair per cycle while result is not stalled; every
//   stage is a registered step of the pipeline and pairs are independent.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When result is stalled the whole pipeline holds, including pair.ready,
//   and resumes without losing or repeating a beat once result is taken.
//   Empty slots in the pipeline carry no beat and produce no result.
// ----------------------------------------------------------------------------
module elastic_circle_collision_core import ecc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ecc_stream_if.sink          pair,
	ecc_stream_if.source        result
);

	logic          en;
	logic          vld_c [0:QB];
	ecc_div_t      d_c   [0:QB];
	ecc_pair_t     p_in;
	ecc_side_t     sd;
	logic [LANES-1:0][QB-1:0] q;
	ecc_result_t   res;
	logic          out_vld_q;
	ecc_result_t   out_data_q;

	assign en         = !out_vld_q || result.ready;
	assign pair.ready = en;
	assign p_in       = pair.data;

	ecc_geom u_geom (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.vld_i (pair.valid),
		.p_i   (p_in),
		.vld_o (vld_c[0]),
		.d_o   (d_c[0])
	);

	for (genvar g = 0; g < QB; g++) begin : g_div
		ecc_div_step u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld_i (vld_c[g]),
			.d_i   (d_c[g]),
			.vld_o (vld_c[g+1]),
			.d_o   (d_c[g+1])
		);
	end

	assign sd = d_c[QB].side;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			q[l] = sd.den_zero ? '0 : d_c[QB].nq[l];
		end
		res.hit = sd.hit;
		if (sd.hit) begin
			res.new_first_vel_x  = ecc_apply(sd.v1x, q[LANE_FX], !sd.neg_x);
			res.new_first_vel_y  = ecc_apply(sd.v1y, q[LANE_FY], !sd.neg_y);
			res.new_second_vel_x = ecc_apply(sd.v2x, q[LANE_SX], sd.neg_x);
			res.new_second_vel_y = ecc_apply(sd.v2y, q[LANE_SY], sd.neg_y);
		end else begin
			res.new_first_vel_x  = sd.v1x;
			res.new_first_vel_y  = sd.v1y;
			res.new_second_vel_x = sd.v2x;
			res.new_second_vel_y = sd.v2y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_c[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res;
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_data_q;

`ifndef NO_ASSERTIONS
	a_rem_entry: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[0] && d_c[0].side.hit && !d_c[0].side.den_zero
		|-> (d_c[0].rem[LANE_FX] < d_c[0].den) && (d_c[0].rem[LANE_SY] < d_c[0].den))
		else $error("divider entry remainder not below denominator");

	a_rem_exit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[QB] && sd.hit && !sd.den_zero
		|-> (d_c[QB].rem[LANE_FY] < d_c[QB].den) && (d_c[QB].rem[LANE_SX] < d_c[QB].den))
		else $error("divider exit remainder not below denominator");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_c[QB] && !sd.hit
		|=> result.valid && !result.data.hit
			&& (result.data.new_first_vel_x == $past(sd.v1x))
			&& (result.data.new_second_vel_y == $past(sd.v2y)))
		else $error("velocities changed without a hit");

	a_hit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		vld_c[0] && d_c[0].side.hit |-> (d_c[0].side.v1x - d_c[0].side.v1x) == 24'sd0
			&& d_c[0].den >= {{(DENW-1){1'b0}}, !d_c[0].side.den_zero})
		else $error("hit with zero denominator not flagged");
`endif

endmodule
